// ===== design/dpt_pkg.sv =====
package dpt_pkg;

	localparam int DIV_W = 30;
	localparam int DEN_W = 18;
	localparam int MUL_BITS = 13;

	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_STOP  = 2'd2;

	localparam logic [1:0] REG_ENABLE   = 2'd0;
	localparam logic [1:0] REG_DOWN_NOM = 2'd1;
	localparam logic [1:0] REG_UP_NOM   = 2'd2;
	localparam logic [1:0] REG_TCONST   = 2'd3;

	localparam logic [DEN_W-1:0] SHIFT_DIVISOR  = 18'd39972;
	localparam logic [15:0]      RESET_TCONST   = 16'd1430;
	localparam logic [13:0]      RESET_DURATION = 14'd600;

endpackage

// ===== design/dpt_div.sv =====
module dpt_div
	import dpt_pkg::*;
(
	input  logic             clk,
	input  logic             load,
	input  logic             step,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic [DIV_W-1:0] quotient
);

	logic [DIV_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_sh;
	logic             fits;

	// One quotient bit per step, restoring form.
	always_comb begin
		rem_sh = {rem_q, quo_q[DIV_W-1]};
		fits   = (rem_sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk) begin
		if (load) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (step) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			if (fits) begin
				rem_q <= DEN_W'(rem_sh - {1'b0, den_q});
			end else begin
				rem_q <= rem_sh[DEN_W-1:0];
			end
		end
	end

	assign quotient = quo_q;

endmodule

// ===== design/doppler_pass_tracker_unit.sv =====
// Doppler corrector for one satellite pass.
// Input words arrive on s_tvalid/s_tready/s_tdata: a one-second tick, a start
// command carrying the pass duration, or a stop command. Every accepted word
// yields exactly one result word on m_tvalid/m_tready/m_tdata with both
// corrected frequencies, the tracking flag and the seconds left.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while the block is idle, which the block does not enforce.
// Start, stop, unused codes, ignored ticks and the tick that ends a pass go from
// idle straight to the finish state to present their result. A tick that
// recomputes the frequencies runs through setup, a bit-serial division of both nominal
// frequencies by the shift divisor (squares formed alongside), a
// bit-serial square root (products formed alongside), a bit-serial
// division of both products by the root, a commit, and the finish state that loads the result.
// One word is processed at a time; s_tready is high only while idle.
// The result sits in an output register, so a stalled receiver holds it while
// the next word is already taken in; the block then waits to publish.
// Reset clears tracking and the counts, sets the duration to 600 seconds and
// the pass constant to 1430, and zeroes both frequencies.
module doppler_pass_tracker_unit
	import dpt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // mode[1:0], pass_seconds[15:2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // downlink_now[27:0], uplink_now[56:28],
	                               // is_tracking[57], seconds_left[71:58]
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [27:0] cfg_data
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SETUP  = 3'd1;
	localparam logic [2:0] ST_DIVC   = 3'd2;
	localparam logic [2:0] ST_ROOT   = 3'd3;
	localparam logic [2:0] ST_DIVP   = 3'd4;
	localparam logic [2:0] ST_COMMIT = 3'd5;
	localparam logic [2:0] ST_FIN    = 3'd6;

	logic [2:0]  state_q;
	logic [4:0]  cnt_q;

	logic        enable_q;
	logic [27:0] dl_nom_q;
	logic [27:0] ul_nom_q;
	logic [15:0] tconst_q;

	logic        tracking_q;
	logic [13:0] elapsed_q;
	logic [13:0] duration_q;
	logic [27:0] down_q;
	logic [28:0] up_q;
	logic [13:0] remaining_q;

	logic        neg_q;
	logic [16:0] mag10_q;

	logic [33:0] sqa_mc_q;
	logic [16:0] sqa_mp_q;
	logic [33:0] sqa_acc_q;
	logic [31:0] sqt_mc_q;
	logic [15:0] sqt_mp_q;
	logic [31:0] sqt_acc_q;

	logic [35:0] rad_q;
	logic [19:0] rem_q;
	logic [17:0] root_q;

	logic [29:0] prod_dn_q;
	logic [29:0] prod_up_q;

	logic        m_tvalid_q;
	logic [71:0] m_tdata_q;

	logic [1:0]  in_mode;
	logic [13:0] in_secs;
	logic        accept;
	logic [13:0] el_inc;
	logic [13:0] mid;
	logic        neg_d;
	logic [13:0] mag_d;
	logic [16:0] mag10_d;
	logic [34:0] rad_sum;
	logic [21:0] rem_sh;
	logic [19:0] trial;
	logic        root_fits;
	logic [17:0] root_nx;
	logic [4:0]  mul_idx;
	logic        mul_on;

	logic        div_load;
	logic        div_step;
	logic [DIV_W-1:0] div0_dividend;
	logic [DIV_W-1:0] div1_dividend;
	logic [DEN_W-1:0] div_divisor;
	logic [DIV_W-1:0] q_dn;
	logic [DIV_W-1:0] q_up;
	logic [12:0] term_dn;
	logic [12:0] term_up;
	logic [28:0] down_sum;
	logic [28:0] up_sum;
	logic        publish;

	assign in_mode  = s_tdata[1:0];
	assign in_secs  = s_tdata[15:2];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign el_inc   = elapsed_q + 14'd1;
	assign publish  = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);

	always_comb begin
		mid     = {1'b0, duration_q[13:1]};
		neg_d   = (elapsed_q < mid);
		mag_d   = neg_d ? (mid - elapsed_q) : (elapsed_q - mid);
		mag10_d = {mag_d, 3'b000} + {2'b00, mag_d, 1'b0};
		rad_sum = {1'b0, sqa_acc_q} + {3'b000, sqt_acc_q};
	end

	always_comb begin
		rem_sh    = {rem_q, rad_q[35:34]};
		trial     = {root_q, 2'b01};
		root_fits = (rem_sh >= {2'b00, trial});
		root_nx   = {root_q[16:0], root_fits};
		mul_on    = (cnt_q < 5'(MUL_BITS));
		mul_idx   = 5'(MUL_BITS - 1) - cnt_q;
	end

	always_comb begin
		div_load = (state_q == ST_SETUP) || (state_q == ST_ROOT && cnt_q == 5'd17);
		div_step = (state_q == ST_DIVC) || (state_q == ST_DIVP);
		if (state_q == ST_SETUP) begin
			div0_dividend = {2'b00, dl_nom_q};
			div1_dividend = {2'b00, ul_nom_q};
			div_divisor   = SHIFT_DIVISOR;
		end else begin
			div0_dividend = prod_dn_q;
			div1_dividend = prod_up_q;
			div_divisor   = root_nx;
		end
	end

	dpt_div u_div_dn (
		.clk      (clk),
		.load     (div_load),
		.step     (div_step),
		.dividend (div0_dividend),
		.divisor  (div_divisor),
		.quotient (q_dn)
	);

	dpt_div u_div_up (
		.clk      (clk),
		.load     (div_load),
		.step     (div_step),
		.dividend (div1_dividend),
		.divisor  (div_divisor),
		.quotient (q_up)
	);

	// A zero root only happens with a zero product, so the term is zero there.
	always_comb begin
		term_dn  = (root_q == '0) ? 13'd0 : q_dn[12:0];
		term_up  = (root_q == '0) ? 13'd0 : q_up[12:0];
		down_sum = neg_q ? ({1'b0, dl_nom_q} + {16'd0, term_dn})
		                 : ({1'b0, dl_nom_q} - {16'd0, term_dn});
		up_sum   = neg_q ? ({1'b0, ul_nom_q} - {16'd0, term_up})
		                 : ({1'b0, ul_nom_q} + {16'd0, term_up});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			dl_nom_q <= '0;
			ul_nom_q <= '0;
			tconst_q <= RESET_TCONST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE:   enable_q <= cfg_data[0];
				REG_DOWN_NOM: dl_nom_q <= cfg_data;
				REG_UP_NOM:   ul_nom_q <= cfg_data;
				REG_TCONST:   tconst_q <= cfg_data[15:0];
				default:      ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			tracking_q  <= 1'b0;
			elapsed_q   <= '0;
			duration_q  <= RESET_DURATION;
			down_q      <= '0;
			up_q        <= '0;
			remaining_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_FIN;
						case (in_mode)
							MODE_START: begin
								duration_q  <= in_secs;
								tracking_q  <= 1'b1;
								elapsed_q   <= '0;
								remaining_q <= in_secs;
							end
							MODE_STOP: begin
								tracking_q  <= 1'b0;
								elapsed_q   <= '0;
								remaining_q <= '0;
								down_q      <= dl_nom_q;
								up_q        <= {1'b0, ul_nom_q};
							end
							MODE_TICK: begin
								if (enable_q && tracking_q) begin
									if (el_inc >= duration_q) begin
										tracking_q  <= 1'b0;
										elapsed_q   <= '0;
										remaining_q <= '0;
										down_q      <= dl_nom_q;
										up_q        <= {1'b0, ul_nom_q};
									end else begin
										elapsed_q   <= el_inc;
										remaining_q <= duration_q - el_inc;
										state_q     <= ST_SETUP;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_SETUP: begin
					cnt_q   <= '0;
					state_q <= ST_DIVC;
				end
				ST_DIVC: begin
					if (cnt_q == 5'(DIV_W - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_ROOT;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_ROOT: begin
					if (cnt_q == 5'd17) begin
						cnt_q   <= '0;
						state_q <= ST_DIVP;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_DIVP: begin
					if (cnt_q == 5'(DIV_W - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_COMMIT;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				ST_COMMIT: begin
					down_q  <= down_sum[27:0];
					up_q    <= up_sum;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (publish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers: squares, root and products, one bit per cycle.
	always_ff @(posedge clk) begin
		if (state_q == ST_SETUP) begin
			neg_q     <= neg_d;
			mag10_q   <= mag10_d;
			sqa_mc_q  <= {17'd0, mag10_d};
			sqa_mp_q  <= mag10_d;
			sqa_acc_q <= '0;
			sqt_mc_q  <= {16'd0, tconst_q};
			sqt_mp_q  <= tconst_q;
			sqt_acc_q <= '0;
		end else if (state_q == ST_DIVC) begin
			sqa_mc_q <= {sqa_mc_q[32:0], 1'b0};
			sqa_mp_q <= {1'b0, sqa_mp_q[16:1]};
			sqt_mc_q <= {sqt_mc_q[30:0], 1'b0};
			sqt_mp_q <= {1'b0, sqt_mp_q[15:1]};
			if (sqa_mp_q[0]) begin
				sqa_acc_q <= sqa_acc_q + sqa_mc_q;
			end
			if (sqt_mp_q[0]) begin
				sqt_acc_q <= sqt_acc_q + sqt_mc_q;
			end
			if (cnt_q == 5'(DIV_W - 1)) begin
				rad_q  <= {1'b0, rad_sum};
				rem_q  <= '0;
				root_q <= '0;
			end
			prod_dn_q <= '0;
			prod_up_q <= '0;
		end else if (state_q == ST_ROOT) begin
			rad_q  <= {rad_q[33:0], 2'b00};
			root_q <= root_nx;
			if (root_fits) begin
				rem_q <= 20'(rem_sh - {2'b00, trial});
			end else begin
				rem_q <= rem_sh[19:0];
			end
			if (mul_on) begin
				prod_dn_q <= {prod_dn_q[28:0], 1'b0}
					+ (q_dn[mul_idx] ? {13'd0, mag10_q} : 30'd0);
				prod_up_q <= {prod_up_q[28:0], 1'b0}
					+ (q_up[mul_idx] ? {13'd0, mag10_q} : 30'd0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (publish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (publish) begin
			m_tdata_q <= {remaining_q, tracking_q, up_q, down_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
